FILE: sv/epvnt_pkg.sv
// Package: shared types, codes and constants of the empirical p-value null table
`default_nettype none
package epvnt_pkg;

    localparam int GENES_DEF = 4096;
    localparam int NULLS_DEF = 64;

    localparam int OP_W    = 2;
    localparam int GENE_W  = 12;
    localparam int ENTRY_W = 6;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 12;
    localparam int P_W     = 16;
    localparam int NPOS_W  = 6;

    localparam int NCNT_W  = 7;
    localparam int GCNT_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QBITS   = 16;
    localparam int QCNT_W  = $clog2(QBITS);

    localparam logic [OP_W-1:0] OP_LOAD_SCORE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RANK  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NULL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_BASED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENE_COUNT = 2'd2;

    localparam logic [NCNT_W-1:0] NULL_COUNT_RST = 7'd64;
    localparam logic [GCNT_W-1:0] GENE_COUNT_RST = 13'd4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic scan_run;
        logic div_init;
        logic div_zero;
        logic div_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_query;
        logic gene_ok;
        logic scan_done;
        logic div_last;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/epvnt_in_if.sv
// Interface: input channel carrying load and query beats
`default_nettype none
interface epvnt_in_if;
    import epvnt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [GENE_W-1:0]         gene_index;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [SCORE_W-1:0] score_value;
    logic [RANK_W-1:0]         rank_value;

    modport source (
        output valid, operation, gene_index, entry_index, score_value, rank_value,
        input  ready
    );
    modport sink (
        input  valid, operation, gene_index, entry_index, score_value, rank_value,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/epvnt_out_if.sv
// Interface: output channel carrying p-value result beats
`default_nettype none
interface epvnt_out_if;
    import epvnt_pkg::*;

    logic              valid;
    logic              ready;
    logic [P_W-1:0]    p_value;
    logic [NPOS_W-1:0] null_position;

    modport source (
        output valid, p_value, null_position,
        input  ready
    );
    modport sink (
        input  valid, p_value, null_position,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/empirical_pvalue_null_table.sv
// Top level: empirical p-value lookup against per-gene null tables
//
//   channel     dir   beat contents
//   i_in_ch     in    operation, gene_index, entry_index, score_value, rank_value
//   o_out_ch    out   p_value, null_position
//   i_cfg_*     in    write enable, register index, data
//
// A load beat is taken while the controller is idle. On a query the scan reads one table
// entry per cycle and compares it in the cycle after, the divider makes one quotient bit
// per cycle, the output register is loaded once it is free, and the controller returns
// to idle to take input. Reset returns the controller to idle, sets the config registers
// to their defaults and clears output valid; tables are not cleared. A stalled result
// sits in the output register while the next beat is taken.
`default_nettype none
module empirical_pvalue_null_table #(
    parameter int GENES = epvnt_pkg::GENES_DEF,
    parameter int NULLS = epvnt_pkg::NULLS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [epvnt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [epvnt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    epvnt_in_if.sink                              i_in_ch,
    epvnt_out_if.source                           o_out_ch
);
    import epvnt_pkg::*;

    t_cmd    cmd;
    t_status status;

    epvnt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    epvnt_dp #(
        .GENES (GENES),
        .NULLS (NULLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_ch     (i_in_ch),
        .o_out_ch    (o_out_ch)
    );

endmodule
`default_nettype wire

FILE: sv/epvnt_ctrl.sv
// Controller: sequences accept, table scan, division and result hand-off
`default_nettype none
module epvnt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire epvnt_pkg::t_status i_status,
    output epvnt_pkg::t_cmd         o_cmd
);
    import epvnt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid && i_status.is_query) begin
                    n_state = i_status.gene_ok ? ST_SCAN : ST_DIV;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid && i_status.is_query) begin
                    if (i_status.gene_ok) begin
                        o_cmd.capture = 1'b1;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        o_cmd.div_zero = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.div_init = i_status.scan_done;
            end
            ST_DIV: begin
                o_cmd.div_run = 1'b1;
            end
            ST_HOLD: begin
                o_cmd.out_load = !i_status.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    a_scan_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.scan_done) |=> (r_state == ST_DIV))
        else $error("scan finish did not start division");

    a_div_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_HOLD))
        else $error("last division step did not reach hold");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_status.out_busy)
        else $error("result loaded over an untaken beat");

endmodule
`default_nettype wire

FILE: sv/epvnt_dp.sv
// Datapath: config registers, null tables, scan compare, divider, output register
`default_nettype none
module epvnt_dp #(
    parameter int GENES = epvnt_pkg::GENES_DEF,
    parameter int NULLS = epvnt_pkg::NULLS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [epvnt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [epvnt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire epvnt_pkg::t_cmd              i_cmd,
    output epvnt_pkg::t_status                o_status,
    epvnt_in_if.sink                          i_in_ch,
    epvnt_out_if.source                       o_out_ch
);
    import epvnt_pkg::*;

    localparam int DEPTH = GENES * NULLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (NULLS > 1) ? $clog2(NULLS) : 1;
    localparam int CW    = $clog2(NULLS + 1);

    // configuration
    logic [NCNT_W-1:0] r_null_count;
    logic              r_rank_based;
    logic [GCNT_W-1:0] r_gene_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_count <= NULL_COUNT_RST;
            r_rank_based <= 1'b0;
            r_gene_count <= GENE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NULL_COUNT: r_null_count <= i_cfg_data[NCNT_W-1:0];
                CFG_RANK_BASED: r_rank_based <= i_cfg_data[0];
                CFG_GENE_COUNT: r_gene_count <= i_cfg_data[GCNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] eff_n;
    always_comb begin
        if (r_null_count == '0) begin
            eff_n = CW'(1);
        end else if (32'(r_null_count) > NULLS) begin
            eff_n = CW'(NULLS);
        end else begin
            eff_n = CW'(r_null_count);
        end
    end

    // input handshake
    logic accept;
    logic gene_ok;
    logic entry_ok;
    logic [AW-1:0] in_base;
    logic [AW-1:0] wr_addr;

    assign i_in_ch.ready = i_cmd.in_ready;
    assign accept   = i_in_ch.valid && i_cmd.in_ready;
    assign gene_ok  = 32'(i_in_ch.gene_index) < GENES;
    assign entry_ok = 32'(i_in_ch.entry_index) < NULLS;
    assign in_base  = AW'(32'(i_in_ch.gene_index) * NULLS);
    assign wr_addr  = in_base + AW'(i_in_ch.entry_index);

    // query registers
    logic [AW-1:0]              r_base;
    logic [CW-1:0]              r_n;
    logic signed [SCORE_W-1:0]  r_score;
    logic [RANK_W-1:0]          r_rank;
    logic                       r_rank_mode;
    logic                       r_up;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_base      <= in_base;
            r_n         <= eff_n;
            r_score     <= i_in_ch.score_value;
            r_rank      <= i_in_ch.rank_value;
            r_rank_mode <= r_rank_based;
            r_up        <= r_rank_based
                ? ({1'b0, i_in_ch.rank_value} < (r_gene_count >> 1))
                : !i_in_ch.score_value[SCORE_W-1];
        end else if (i_cmd.div_init && i_cmd.div_zero) begin
            r_n <= eff_n;
        end
    end

    // read issue
    logic [CW-1:0] r_iss;
    logic          issue;
    logic [CW-1:0] entry_sel;
    logic [AW-1:0] rd_addr;

    assign issue     = i_cmd.scan_run && (r_iss < r_n);
    assign entry_sel = r_up ? r_iss : (r_n - CW'(1) - r_iss);
    assign rd_addr   = r_base + AW'(entry_sel[PW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= '0;
        end else if (i_cmd.capture) begin
            r_iss <= '0;
        end else if (issue) begin
            r_iss <= r_iss + CW'(1);
        end
    end

    // null tables
    logic signed [SCORE_W-1:0] mem_score [DEPTH];
    logic [RANK_W-1:0]         mem_rank  [DEPTH];
    logic signed [SCORE_W-1:0] r_rd_score;
    logic [RANK_W-1:0]         r_rd_rank;
    logic                      r_rd_valid;
    logic [CW-1:0]             r_rd_step;

    always_ff @(posedge i_clk) begin
        if (accept && gene_ok && entry_ok && i_in_ch.operation == OP_LOAD_SCORE) begin
            mem_score[wr_addr] <= i_in_ch.score_value;
        end
        if (accept && gene_ok && entry_ok && i_in_ch.operation == OP_LOAD_RANK) begin
            mem_rank[wr_addr] <= i_in_ch.rank_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_score <= mem_score[rd_addr];
            r_rd_rank  <= mem_rank[rd_addr];
            r_rd_step  <= r_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
        end
    end

    // compare
    logic hit;
    always_comb begin
        if (r_rank_mode) begin
            hit = r_up ? (r_rank <= r_rd_rank) : (r_rank >= r_rd_rank);
        end else begin
            hit = r_up ? (r_score >= r_rd_score) : (r_score <= r_rd_score);
        end
    end

    logic scan_done;
    assign scan_done = r_rd_valid && (hit || r_rd_step == r_n - CW'(1));

    // divider: quotient of pos * 2^16 / n, one bit per cycle
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_pos;
    logic [P_W-1:0]    r_quo;
    logic [QCNT_W-1:0] r_dcnt;
    logic [CW:0]       rem_x2;
    logic              rem_ge;
    logic [CW:0]       rem_sub;

    assign rem_x2  = {r_rem, 1'b0};
    assign rem_ge  = rem_x2 >= {1'b0, r_n};
    assign rem_sub = rem_x2 - {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= i_cmd.div_zero ? '0 : r_rd_step;
            r_pos  <= i_cmd.div_zero ? '0 : r_rd_step;
            r_dcnt <= '0;
        end else if (i_cmd.div_run) begin
            r_rem  <= rem_ge ? rem_sub[CW-1:0] : rem_x2[CW-1:0];
            r_quo  <= {r_quo[P_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + QCNT_W'(1);
        end
    end

    // output register
    logic              r_out_valid;
    logic [P_W-1:0]    r_p;
    logic [NPOS_W-1:0] r_npos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_p    <= r_quo;
            r_npos <= NPOS_W'(r_pos);
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.p_value       = r_p;
    assign o_out_ch.null_position = r_npos;

    always_comb begin
        o_status.in_valid  = i_in_ch.valid;
        o_status.is_query  = i_in_ch.operation == OP_QUERY;
        o_status.gene_ok   = gene_ok;
        o_status.scan_done = scan_done;
        o_status.div_last  = r_dcnt == '1;
        o_status.out_busy  = r_out_valid && !o_out_ch.ready;
    end

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_rd_step < r_n))
        else $error("scan step beyond null count");

    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_run |-> (r_rem < r_n))
        else $error("divider remainder not below divisor");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule
`default_nettype wire
